// ===== rtl/i2c_target_register_emulator_assert.svh =====
// Assertion macros used by the checker file of the register emulator.
`ifndef I2C_TARGET_REGISTER_EMULATOR_ASSERT_SVH
`define I2C_TARGET_REGISTER_EMULATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define I2CRE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cre assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define I2CRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cre assertion failed");

`endif

// ===== rtl/i2cre_pkg.sv =====
`default_nettype none
package i2cre_pkg;

  localparam int REG_SPACE_DEF = 256;
  localparam logic [3:0] MAX_BURST = 4'd9;

  localparam logic [1:0] CMD_BURST = 2'd0;
  localparam logic [1:0] CMD_ADDR  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TX    = 2'd3;

  localparam logic [6:0] LED_ADDR    = 7'h55;
  localparam logic [6:0] MAG_ADDR_LO = 7'h20;
  localparam logic [6:0] MAG_ADDR_HI = 7'h23;
  localparam logic [7:0] DATA_REG    = 8'h24;
  localparam logic [7:0] STATUS_REG  = 8'h34;
  localparam logic [7:0] ID_REG      = 8'h36;
  localparam logic [7:0] ID_VALUE    = 8'h22;
  localparam logic [7:0] STATUS_NEW  = 8'h80;
  localparam logic [3:0] NEG_COUNT   = 4'd9;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  slave_addr;
    logic [7:0]  data_byte;
    logic [7:0]  reg_addr;
    logic [3:0]  byte_count;
    logic [23:0] group_first;
    logic [23:0] group_second;
    logic [23:0] group_third;
  } i2cre_in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic       led_written;
    logic       mode_setup_needed;
  } i2cre_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch;
    logic bus_exec;
    logic burst_wr;
    logic rd_issue;
    logic rd_finish;
    logic load_out;
  } i2cre_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [1:0] cmd;
    logic       burst_ok;
    logic       burst_last;
  } i2cre_stat_t;

  // Burst byte i of the three big-endian groups packed as one 72-bit word.
  function automatic logic [7:0] burst_byte(input logic [71:0] g, input logic [3:0] i);
    logic [7:0] b;
    b = '0;
    unique case (i)
      4'd0: b = g[71:64];
      4'd1: b = g[63:56];
      4'd2: b = g[55:48];
      4'd3: b = g[47:40];
      4'd4: b = g[39:32];
      4'd5: b = g[31:24];
      4'd6: b = g[23:16];
      4'd7: b = g[15:8];
      4'd8: b = g[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic is_mag(input logic [6:0] a);
    return (a >= MAG_ADDR_LO) && (a <= MAG_ADDR_HI);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/i2cre_ctrl.sv =====
`default_nettype none
module i2cre_ctrl
  import i2cre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  i2cre_stat_t stat,
  output i2cre_ctl_t  ctl
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_WRITE    = 3'd2;
  localparam logic [2:0] ST_RD_DATA  = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat.cmd)
          CMD_BURST: state_nxt = stat.burst_ok ? ST_WRITE : ST_DONE;
          CMD_ADDR, CMD_RX: begin
            ctl.bus_exec = 1'b1;
            state_nxt    = ST_DONE;
          end
          CMD_TX: begin
            ctl.rd_issue = 1'b1;
            state_nxt    = ST_RD_DATA;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_WRITE: begin
        ctl.burst_wr = 1'b1;
        if (stat.burst_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_DATA: begin
        ctl.rd_finish = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_r || out_ready) begin
          ctl.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/i2cre_datapath.sv =====
`default_nettype none
module i2cre_datapath
  import i2cre_pkg::*;
#(
  parameter int REG_SPACE = REG_SPACE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  i2cre_in_t   in_data,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  i2cre_ctl_t  ctl,
  output i2cre_stat_t stat,
  output i2cre_out_t  out_data
);

  localparam int ADDR_W = $clog2(REG_SPACE);
  localparam bit DATA_IN_SPACE = (int'(DATA_REG) < REG_SPACE);
  localparam logic [ADDR_W-1:0] DATA_IDX = ADDR_W'(DATA_REG);

  i2cre_in_t      item_r;
  logic [71:0]    groups_r;
  logic [3:0]     idx_r;
  logic           cfg_serial_r;

  logic [6:0]     bus_addr_r;
  logic [7:0]     byte_idx_r;
  logic [7:0]     led_ptr_r;
  logic [7:0]     sensor_ptr_r;
  logic [7:0]     red_r, green_r, blue_r;
  logic           setup_r;
  logic           led_wr_r;
  logic [7:0]     tx_r;

  logic [REG_SPACE-1:0] present_r;
  logic [REG_SPACE-1:0] fresh_r;
  logic [7:0]           mem [REG_SPACE];
  logic [7:0]           mem_rdata_r;

  logic [7:0]     rd_addr_r;
  logic           rd_mag_r;
  logic           rd_in_space_r;

  i2cre_out_t     out_r;

  // Burst write address and data.
  logic [7:0]        wr_addr;
  logic [ADDR_W-1:0] wr_idx;
  logic              wr_in_space;
  logic [7:0]        wr_byte;
  logic              neg_burst;

  // Shadow read-out.
  logic [7:0]        rd_addr;
  logic [ADDR_W-1:0] rd_issue_idx;
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]        rd_tx;
  logic              fresh_clr;
  logic [ADDR_W-1:0] clr_idx;

  assign neg_burst    = (in_data.reg_addr == DATA_REG) && (in_data.byte_count == NEG_COUNT);
  assign wr_addr      = item_r.reg_addr + {4'd0, idx_r};
  assign wr_idx       = wr_addr[ADDR_W-1:0];
  assign wr_in_space  = ({1'b0, wr_addr} < 9'(REG_SPACE));
  assign wr_byte      = burst_byte(groups_r, idx_r);
  assign rd_addr      = sensor_ptr_r + byte_idx_r;
  assign rd_issue_idx = rd_addr[ADDR_W-1:0];
  assign rd_idx       = rd_addr_r[ADDR_W-1:0];

  assign stat.cmd        = item_r.cmd;
  assign stat.burst_ok   = (item_r.byte_count != 4'd0) && (item_r.byte_count <= MAX_BURST);
  assign stat.burst_last = (idx_r == item_r.byte_count - 4'd1);

  always_comb begin
    rd_tx     = '0;
    fresh_clr = 1'b0;
    clr_idx   = rd_idx;
    if (rd_mag_r) begin
      if (rd_addr_r == ID_REG) begin
        rd_tx = ID_VALUE;
      end else if (rd_in_space_r && present_r[rd_idx]) begin
        if (rd_addr_r == STATUS_REG) begin
          // The status register reports fresh data at the data register once.
          if (DATA_IN_SPACE && present_r[DATA_IDX] && fresh_r[DATA_IDX]) begin
            rd_tx     = STATUS_NEW;
            fresh_clr = 1'b1;
            clr_idx   = DATA_IDX;
          end
        end else begin
          rd_tx     = mem_rdata_r;
          fresh_clr = 1'b1;
        end
      end
    end
  end

  // Item latch and burst groups; a full burst at the data register is negated.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      item_r   <= in_data;
      groups_r <= neg_burst
                ? {-in_data.group_first, -in_data.group_second, -in_data.group_third}
                : {in_data.group_first, in_data.group_second, in_data.group_third};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_serial_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_serial_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (ctl.latch) begin
      idx_r <= '0;
    end else if (ctl.burst_wr) begin
      idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_addr_r   <= '0;
      byte_idx_r   <= '0;
      led_ptr_r    <= '0;
      sensor_ptr_r <= '0;
      red_r        <= '0;
      green_r      <= '0;
      blue_r       <= '0;
      setup_r      <= 1'b0;
      led_wr_r     <= 1'b0;
      tx_r         <= '0;
    end else begin
      if (ctl.latch) begin
        led_wr_r <= 1'b0;
        tx_r     <= '0;
      end
      if (ctl.bus_exec) begin
        if (item_r.cmd == CMD_ADDR) begin
          bus_addr_r <= item_r.slave_addr;
          byte_idx_r <= '0;
        end else begin
          if (bus_addr_r == LED_ADDR) begin
            if (!cfg_serial_r) begin
              setup_r <= 1'b1;
            end
            if (byte_idx_r == 8'd0 || item_r.data_byte[7]) begin
              led_ptr_r <= {1'b0, item_r.data_byte[6:0]};
            end else begin
              priority case (led_ptr_r)
                8'd1: blue_r  <= {2{item_r.data_byte[3:0]}};
                8'd2: green_r <= {2{item_r.data_byte[3:0]}};
                8'd3: red_r   <= {2{item_r.data_byte[3:0]}};
                default: ;
              endcase
              led_ptr_r <= led_ptr_r + 8'd1;
              led_wr_r  <= 1'b1;
            end
          end else if (is_mag(bus_addr_r) && byte_idx_r == 8'd0) begin
            sensor_ptr_r <= item_r.data_byte;
          end
          byte_idx_r <= byte_idx_r + 8'd1;
        end
      end
      if (ctl.rd_issue) begin
        byte_idx_r <= byte_idx_r + 8'd1;
      end
      if (ctl.rd_finish) begin
        tx_r <= rd_tx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_issue) begin
      rd_addr_r     <= rd_addr;
      rd_mag_r      <= is_mag(bus_addr_r);
      rd_in_space_r <= ({1'b0, rd_addr} < 9'(REG_SPACE));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      fresh_r   <= '0;
    end else begin
      if (ctl.burst_wr && wr_in_space) begin
        present_r[wr_idx] <= 1'b1;
        fresh_r[wr_idx]   <= 1'b1;
      end
      if (ctl.rd_finish && fresh_clr) begin
        fresh_r[clr_idx] <= 1'b0;
      end
    end
  end

  // Shadow value store, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (ctl.burst_wr && wr_in_space) begin
      mem[wr_idx] <= wr_byte;
    end
    if (ctl.rd_issue) begin
      mem_rdata_r <= mem[rd_issue_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_r.tx_byte           <= tx_r;
      out_r.led_red           <= red_r;
      out_r.led_green         <= green_r;
      out_r.led_blue          <= blue_r;
      out_r.led_written       <= led_wr_r;
      out_r.mode_setup_needed <= setup_r;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== rtl/i2c_target_register_emulator.sv =====
// Channel   Ports                          Transfer when
// input     in_valid, in_ready, in_data    in_valid && in_ready
// result    out_valid, out_ready, out_data out_valid && out_ready
// config    cfg_wr_en, cfg_wr_data         cfg_wr_en
//
// One item is worked on at a time. A valid burst takes dispatch, one write state
// per byte (the shadow store takes one write a cycle) and done; address match and
// received byte take dispatch and done, a requested byte also a read-data state
// for the registered store read. Reset clears all marks and bus state at once. A
// result held by a stalled output does not stop the next transfer in; the block
// waits only if a second result is ready before the first leaves.
`default_nettype none
module i2c_target_register_emulator
  import i2cre_pkg::*;
#(
  parameter int REG_SPACE = REG_SPACE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  i2cre_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output i2cre_out_t out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  i2cre_ctl_t  ctl;
  i2cre_stat_t stat;

  i2cre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  i2cre_datapath #(
    .REG_SPACE (REG_SPACE)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/i2cre_checker.sv =====
`default_nettype none
`include "i2c_target_register_emulator_assert.svh"
module i2cre_checker
  import i2cre_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire i2cre_out_t out_data
);

  // A stalled result holds.
  `I2CRE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // One item at a time: the input closes right after a transfer.
  `I2CRE_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

  // The setup request is sticky once shown.
  `I2CRE_ASSERT_NEXT(a_setup_sticky, clk, rst_n, out_valid && out_data.mode_setup_needed, !out_valid || out_data.mode_setup_needed)

  // An LED write comes from a received byte, which never returns data.
  `I2CRE_ASSERT_IMPLIES(a_led_no_tx, clk, rst_n, out_valid && out_data.led_written, out_data.tx_byte == 8'd0)

endmodule

bind i2c_target_register_emulator i2cre_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
